// ----- rtl/core/adll_pkg.sv -----
// Shared types and codes for the array doubly linked list block.
// No dependencies; imported by adll_store, adll_seq and the top level.

package adll_pkg;

  localparam int MAX_RES = 32;
  localparam int CNT_W   = $clog2(MAX_RES) + 1;

  typedef enum logic [1:0] {
    CMD_FWD = 2'd0,
    CMD_BWD = 2'd1,
    CMD_DEL = 2'd2,
    CMD_INS = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic val;
    logic nxt;
    logic prv;
  } wr_en_t;

endpackage

// ----- rtl/core/adll_store.sv -----
// Value, next-link and prev-link memories with per-entry valid bits.
// Depends on adll_pkg; an entry never written reads as its reset contents.

module adll_store import adll_pkg::*; #(
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [AW-1:0]      raddr,
  output logic signed [31:0] q_val,
  output logic [AW-1:0]      q_next,
  output logic [AW-1:0]      q_prev,
  input  wr_en_t             we,
  input  logic [AW-1:0]      next_waddr,
  input  logic [AW-1:0]      prev_waddr,
  input  logic [AW-1:0]      next_wdata,
  input  logic [AW-1:0]      prev_wdata,
  input  logic signed [31:0] val_wdata
);

  logic signed [31:0] val_mem  [DEPTH];
  logic [AW-1:0]      next_mem [DEPTH];
  logic [AW-1:0]      prev_mem [DEPTH];
  logic [DEPTH-1:0]   val_ok, next_ok, prev_ok;

  logic signed [31:0] val_raw;
  logic [AW-1:0]      next_raw, prev_raw, raddr_q;
  logic               val_hit, next_hit, prev_hit;

  // header links to itself, free entries chained, last free entry null
  function automatic logic [AW-1:0] next_init(input logic [AW-1:0] a);
    int ia;
    ia = int'(a);
    if (ia == 1) return AW'(1);
    if (ia >= 2 && ia < DEPTH - 1) return AW'(ia + 1);
    return '0;
  endfunction

  function automatic logic [AW-1:0] prev_init(input logic [AW-1:0] a);
    return (int'(a) == 1) ? AW'(1) : '0;
  endfunction

  always_ff @(posedge clk) begin
    if (we.val) val_mem[next_waddr] <= val_wdata;
    if (we.nxt) next_mem[next_waddr] <= next_wdata;
    if (we.prv) prev_mem[prev_waddr] <= prev_wdata;
    val_raw  <= val_mem[raddr];
    next_raw <= next_mem[raddr];
    prev_raw <= prev_mem[raddr];
    val_hit  <= val_ok[raddr];
    next_hit <= next_ok[raddr];
    prev_hit <= prev_ok[raddr];
    raddr_q  <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val_ok  <= '0;
      next_ok <= '0;
      prev_ok <= '0;
    end else begin
      if (we.val) val_ok[next_waddr] <= 1'b1;
      if (we.nxt) next_ok[next_waddr] <= 1'b1;
      if (we.prv) prev_ok[prev_waddr] <= 1'b1;
    end
  end

  assign q_val  = val_hit ? val_raw : '0;
  assign q_next = next_hit ? next_raw : next_init(raddr_q);
  assign q_prev = prev_hit ? prev_raw : prev_init(raddr_q);

endmodule

// ----- rtl/core/adll_seq.sv -----
// Command sequencer: walks links, edits links and the free list, holds the result item.
// Depends on adll_pkg; drives the memory ports of adll_store.

module adll_seq import adll_pkg::*; #(
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  cmd_t               in_cmd,
  input  logic [4:0]         in_node,
  input  logic signed [31:0] in_value,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic signed [31:0] out_value,
  output logic [4:0]         out_node,
  output status_t            out_status,
  output logic               out_last,
  output logic [AW-1:0]      raddr,
  input  logic signed [31:0] q_val,
  input  logic [AW-1:0]      q_next,
  input  logic [AW-1:0]      q_prev,
  output wr_en_t             we,
  output logic [AW-1:0]     next_waddr,
  output logic [AW-1:0]     prev_waddr,
  output logic [AW-1:0]     next_wdata,
  output logic [AW-1:0]     prev_wdata,
  output logic signed [31:0] val_wdata
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ISSUE = 9'b000000010,
    S_TEVAL = 9'b000000100,
    S_DEVAL = 9'b000001000,
    S_DFIN  = 9'b000010000,
    S_IRD   = 9'b000100000,
    S_IEVAL = 9'b001000000,
    S_IFIN  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t             state;
  cmd_t               cmd;
  logic [AW-1:0]      loc, cur, fhead, succ, save;
  logic [CNT_W-1:0]   cnt;
  logic signed [31:0] item;
  logic               more;

  logic               accept, node_ok;
  logic [AW-1:0]      nxt;
  logic               at_end;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign node_ok  = (in_node != '0) && (int'(in_node) < DEPTH);
  assign nxt      = (cmd == CMD_FWD) ? q_next : q_prev;
  assign at_end   = (nxt == loc) || (nxt == '0);
  assign raddr    = (state == S_IRD) ? fhead : cur;

  always_comb begin
    we         = '0;
    next_waddr = loc;
    prev_waddr = loc;
    next_wdata = fhead;
    prev_wdata = loc;
    val_wdata  = item;
    case (state)
      S_DEVAL: begin
        we.nxt     = 1'b1;
        we.prv     = 1'b1;
        next_waddr = q_prev;
        next_wdata = q_next;
        prev_waddr = q_next;
        prev_wdata = q_prev;
      end
      S_DFIN: begin
        we.nxt = 1'b1;
      end
      S_IEVAL: begin
        we.val     = 1'b1;
        we.nxt     = 1'b1;
        we.prv     = 1'b1;
        next_waddr = fhead;
        next_wdata = succ;
        prev_waddr = fhead;
      end
      S_IFIN: begin
        we.nxt     = 1'b1;
        we.prv     = 1'b1;
        next_wdata = save;
        prev_waddr = succ;
        prev_wdata = save;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      fhead    <= AW'(2);
      more     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd  <= in_cmd;
            item <= in_value;
            loc  <= AW'(in_node);
            cur  <= AW'(in_node);
            cnt  <= '0;
            more <= 1'b0;
            if (!node_ok) begin
              out_value  <= '0;
              out_node   <= '0;
              out_status <= ST_NULL;
              out_last   <= 1'b1;
              m_tvalid   <= 1'b1;
              state      <= S_OUT;
            end else if (in_cmd == CMD_INS && fhead == '0) begin
              out_value  <= '0;
              out_node   <= '0;
              out_status <= ST_OVF;
              out_last   <= 1'b1;
              m_tvalid   <= 1'b1;
              state      <= S_OUT;
            end else begin
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          case (cmd)
            CMD_DEL: state <= S_DEVAL;
            CMD_INS: state <= S_IRD;
            default: state <= S_TEVAL;
          endcase
        end
        S_TEVAL: begin
          if (cnt == '0) begin
            if (at_end) begin
              out_value  <= '0;
              out_node   <= '0;
              out_status <= ST_EMPTY;
              out_last   <= 1'b1;
              m_tvalid   <= 1'b1;
              more       <= 1'b0;
              state      <= S_OUT;
            end else begin
              cur   <= nxt;
              cnt   <= CNT_W'(1);
              state <= S_ISSUE;
            end
          end else begin
            out_value  <= q_val;
            out_node   <= 5'(cur);
            out_status <= ST_OK;
            out_last   <= at_end || (cnt == CNT_W'(MAX_RES));
            more       <= !(at_end || (cnt == CNT_W'(MAX_RES)));
            m_tvalid   <= 1'b1;
            cur        <= nxt;
            cnt        <= cnt + 1'b1;
            state      <= S_OUT;
          end
        end
        S_DEVAL: state <= S_DFIN;
        S_DFIN: begin
          fhead      <= loc;
          out_value  <= '0;
          out_node   <= 5'(loc);
          out_status <= ST_OK;
          out_last   <= 1'b1;
          m_tvalid   <= 1'b1;
          state      <= S_OUT;
        end
        S_IRD: begin
          succ  <= q_next;
          save  <= fhead;
          state <= S_IEVAL;
        end
        S_IEVAL: begin
          fhead <= q_next;
          state <= S_IFIN;
        end
        S_IFIN: begin
          out_value  <= '0;
          out_node   <= 5'(save);
          out_status <= ST_OK;
          out_last   <= 1'b1;
          m_tvalid   <= 1'b1;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= more ? S_ISSUE : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a result item is pending");

  a_fhead_range: assert property (@(posedge clk) disable iff (rst)
    int'(fhead) < DEPTH)
    else $error("free head out of range");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_TEVAL |-> int'(cnt) <= MAX_RES)
    else $error("walk count beyond limit");

  a_reject: assert property (@(posedge clk) disable iff (rst)
    accept && !node_ok |=> m_tvalid && out_status == ST_NULL && out_last)
    else $error("null node not rejected");

endmodule

// ----- rtl/core/array_doubly_linked_list.sv -----
// Circular doubly linked list in arrays with a free list; one item in work at a time.
// Order: reject or overflow goes straight to the result; delete runs ISSUE, DEVAL, DFIN;
// insert runs ISSUE, IRD, IEVAL, IFIN; a walk reads each visited node from the registered link memory.
// Throughput: next item taken once the last result item of the current one is taken.
// Reset: synchronous, active high; valid bits restore all three arrays at once.
// Depends on adll_pkg, adll_store and adll_seq.

module array_doubly_linked_list import adll_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // command[1:0], node[6:2], value[38:7], zero[39]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // value_res[31:0], node_res[36:32], status[38:37], zero[39]
  output logic        m_tlast
);

  localparam int AW = $clog2(DEPTH);

  logic signed [31:0] q_val, val_wdata, value_res;
  logic [AW-1:0]      raddr, q_next, q_prev;
  logic [AW-1:0]      next_waddr, prev_waddr, next_wdata, prev_wdata;
  wr_en_t             we;
  logic [4:0]         node_res;
  status_t            status;

  adll_store #(.DEPTH(DEPTH)) u_store (
    .clk        (clk),
    .rst        (rst),
    .raddr      (raddr),
    .q_val      (q_val),
    .q_next     (q_next),
    .q_prev     (q_prev),
    .we         (we),
    .next_waddr (next_waddr),
    .prev_waddr (prev_waddr),
    .next_wdata (next_wdata),
    .prev_wdata (prev_wdata),
    .val_wdata  (val_wdata)
  );

  adll_seq #(.DEPTH(DEPTH)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .in_cmd     (cmd_t'(s_tdata[1:0])),
    .in_node    (s_tdata[6:2]),
    .in_value   (s_tdata[38:7]),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .out_value  (value_res),
    .out_node   (node_res),
    .out_status (status),
    .out_last   (m_tlast),
    .raddr      (raddr),
    .q_val      (q_val),
    .q_next     (q_next),
    .q_prev     (q_prev),
    .we         (we),
    .next_waddr (next_waddr),
    .prev_waddr (prev_waddr),
    .next_wdata (next_wdata),
    .prev_wdata (prev_wdata),
    .val_wdata  (val_wdata)
  );

  assign m_tdata = {1'b0, status, node_res, value_res};

endmodule
